// ===== rtl/core/geomagnetic_field_harmonic_sum_macros.svh =====
// Assertion macros used by the checker file of the harmonic sum block.
// Depends on nothing; included by file name where assertions are written.
`ifndef GEOMAGNETIC_FIELD_HARMONIC_SUM_MACROS_SVH
`define GEOMAGNETIC_FIELD_HARMONIC_SUM_MACROS_SVH

// Consequent must hold at the same edge as the antecedent.
`define GFHS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("harmonic sum check failed (same cycle)");

// Consequent must hold at the edge that follows the antecedent.
`define GFHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("harmonic sum check failed (next cycle)");

`endif

// ===== rtl/core/gfhs_pkg.sv =====
// Shared types, constants, coefficient tables and saturating helpers
// of the harmonic sum block. Depends on nothing.
`default_nettype none

package gfhs_pkg;

   localparam int CSR_ADDR_W  = 3;
   localparam int THR_W       = 29;
   localparam int OUT_W       = 48;
   localparam int NORM_W      = 44;
   localparam int K_W         = 28;
   localparam int TAB_DEPTH   = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;
   localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [3:0]         degree;
      logic [3:0]         order;
      logic [30:0]        radius_power;
      logic signed [31:0] coef_g;
      logic signed [31:0] coef_h;
      logic signed [29:0] cos_m_lon;
      logic signed [29:0] sin_m_lon;
      logic signed [31:0] legendre_p;
      logic signed [31:0] legendre_dp;
      logic [28:0]        cos_lat;
      logic signed [29:0] sin_lat;
      logic               last;
      logic               term_ok;
      logic               order_one;
      logic               degree_one;
   } term_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] q;
      logic signed [63:0] raw;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [28:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        ovf;
      logic [47:0] quot;
   } div_rsp_type;

   typedef logic [NORM_W-1:0] norm_tab_type [TAB_DEPTH];
   typedef logic [K_W-1:0]    k_tab_type    [TAB_DEPTH];

   // Elaboration-time helpers used only to build the constant tables.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_in;
      r = '0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] pole_norm_calc(input int n);
      logic [63:0] c;
      logic [63:0] s;
      c = 64'd1;
      for (int i = 1; i <= n; i++) begin
         c = udiv64(c * 64'd2 * 64'(2 * i - 1), 64'(i));
      end
      s = isqrt64(udiv64(64'(2 * n) << 56, 64'(n + 1)));
      return (c * s + (64'd1 << (n - 1))) >> n;
   endfunction

   function automatic logic [63:0] pole_k_calc(input int n);
      logic [63:0] num;
      logic [63:0] den;
      num = 64'((n - 1) * (n - 1) - 1) << 28;
      den = 64'((2 * n - 1) * (2 * n - 3));
      return udiv64(num + (den >> 1), den);
   endfunction

   function automatic norm_tab_type build_norm_tab();
      norm_tab_type t;
      for (int n = 0; n < TAB_DEPTH; n++) begin
         t[n] = (n == 0) ? '0 : NORM_W'(pole_norm_calc(n));
      end
      return t;
   endfunction

   function automatic k_tab_type build_k_tab();
      k_tab_type t;
      for (int n = 0; n < TAB_DEPTH; n++) begin
         t[n] = (n < 2) ? '0 : K_W'(pole_k_calc(n));
      end
      return t;
   endfunction

   localparam norm_tab_type NORM_TAB = build_norm_tab();
   localparam k_tab_type    K_TAB    = build_k_tab();

   function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? S64_MIN : S64_MAX;
      return s;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat48(input logic signed [63:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 64'sh0000_7fff_ffff_ffff)      r = {1'b0, {(OUT_W-1){1'b1}}};
      else if (v < -64'sh0000_8000_0000_0000) r = {1'b1, {(OUT_W-1){1'b0}}};
      else                                    r = v[OUT_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gfhs_front.sv =====
// Front end: takes input transfers, checks and classifies each term.
// Depends on gfhs_pkg; feeds gfhs_queue.
`default_nettype none

module gfhs_front
   import gfhs_pkg::*;
#(
   parameter int MAX_DEGREE = 12
) (
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_degree,
   input  wire logic [3:0]         req_order,
   input  wire logic [30:0]        req_radius_power,
   input  wire logic signed [31:0] req_coef_g,
   input  wire logic signed [31:0] req_coef_h,
   input  wire logic signed [29:0] req_cos_m_lon,
   input  wire logic signed [29:0] req_sin_m_lon,
   input  wire logic signed [31:0] req_legendre_p,
   input  wire logic signed [31:0] req_legendre_dp,
   input  wire logic [28:0]        req_cos_lat,
   input  wire logic signed [29:0] req_sin_lat,
   input  wire logic               req_last,
   input  wire logic               queue_full,
   output logic                    push,
   output term_type                entry
);

   localparam logic [4:0] MAX_DEG = 5'(MAX_DEGREE);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      entry              = '0;
      entry.degree       = req_degree;
      entry.order        = req_order;
      entry.radius_power = req_radius_power;
      entry.coef_g       = req_coef_g;
      entry.coef_h       = req_coef_h;
      entry.cos_m_lon    = req_cos_m_lon;
      entry.sin_m_lon    = req_sin_m_lon;
      entry.legendre_p   = req_legendre_p;
      entry.legendre_dp  = req_legendre_dp;
      entry.cos_lat      = req_cos_lat;
      entry.sin_lat      = req_sin_lat;
      entry.last         = req_last;
      // A term out of range contributes nothing but still carries its last flag.
      entry.term_ok      = (req_degree != 4'd0) && ({1'b0, req_degree} <= MAX_DEG) &&
                           (req_order <= req_degree);
      entry.order_one    = (req_order == 4'd1);
      entry.degree_one   = (req_degree == 4'd1);
   end

endmodule

`default_nettype wire

// ===== rtl/core/gfhs_queue.sv =====
// Short term queue that decouples the front end from the back end.
// Depends on gfhs_pkg.
`default_nettype none

module gfhs_queue
   import gfhs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire term_type push_data,
   input  wire logic     pop,
   output term_type      pop_data,
   output logic          full,
   output logic          empty
);

   term_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ===== rtl/core/gfhs_mul.sv =====
// Shared Q28 multiplier: 64 by 64 signed, four 32 by 32 partial products,
// then rounding half away from zero and saturation. Depends on gfhs_pkg.
`default_nettype none

module gfhs_mul
   import gfhs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type req,
   output mul_rsp_type      rsp
);

   typedef enum logic [1:0] {M_IDLE, M_PP, M_ROUND} mstate_type;

   mstate_type         state_ff, state_in;
   logic [63:0]        ua_ff, ua_in;
   logic [63:0]        ub_ff, ub_in;
   logic               neg_ff, neg_in;
   logic [127:0]       acc_ff, acc_in;
   logic [1:0]         step_ff, step_in;
   logic signed [63:0] q_ff, q_in;
   logic signed [63:0] raw_ff, raw_in;
   logic               done_ff, done_in;

   logic [31:0]  a_part, b_part;
   logic [63:0]  pp;
   logic [127:0] pp_shift;
   logic [127:0] rsum;
   logic [63:0]  rmag, lim;
   logic         ovf;

   always_comb begin
      a_part = step_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      b_part = step_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      pp     = 64'(a_part) * 64'(b_part);
      unique case ({step_ff[1], step_ff[0]})
         2'b00:   pp_shift = 128'(pp);
         2'b01,
         2'b10:   pp_shift = 128'(pp) << 32;
         default: pp_shift = 128'(pp) << 64;
      endcase
      rsum = acc_ff + 128'(1 << 27);
      lim  = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      ovf  = (|rsum[127:92]) || (rsum[91:28] > lim);
      rmag = ovf ? lim : rsum[91:28];
   end

   always_comb begin
      state_in = state_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      q_in     = q_ff;
      raw_in   = raw_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               ua_in    = req.a[63] ? 64'(-req.a) : 64'(req.a);
               ub_in    = req.b[63] ? 64'(-req.b) : 64'(req.b);
               neg_in   = req.a[63] != req.b[63];
               acc_in   = '0;
               step_in  = '0;
               state_in = M_PP;
            end
         end
         M_PP: begin
            acc_in  = acc_ff + pp_shift;
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd3) state_in = M_ROUND;
         end
         default: begin
            q_in     = neg_ff ? -$signed(rmag) : $signed(rmag);
            raw_in   = neg_ff ? -$signed(acc_ff[63:0]) : $signed(acc_ff[63:0]);
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      raw_ff  <= raw_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q    = q_ff;
   assign rsp.raw  = raw_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gfhs_div.sv =====
// Bit-serial divider for the east sum: floor(u * 2^28 / d), 48 quotient
// bits, with an overflow flag when the quotient reaches 2^48. Depends on gfhs_pkg.
`default_nettype none

module gfhs_div
   import gfhs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type   state_ff, state_in;
   logic [28:0]  den_ff, den_in;
   logic [28:0]  rem_ff, rem_in;
   logic [47:0]  sh_ff, sh_in;
   logic [47:0]  quot_ff, quot_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         ovf_ff, ovf_in;
   logic         done_ff, done_in;

   logic [29:0]  trial;
   logic [29:0]  diff;
   logic         ge;

   always_comb begin
      trial = {rem_ff, sh_ff[47]};
      diff  = trial - 30'(den_ff);
      ge    = trial >= 30'(den_ff);
   end

   always_comb begin
      state_in = state_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (req.start) begin
               den_in  = req.divisor;
               ovf_in  = req.dividend[63:20] >= 44'(req.divisor);
               rem_in  = req.dividend[48:20];
               sh_in   = {req.dividend[19:0], 28'd0};
               quot_in = '0;
               cnt_in  = 6'd47;
               if (req.dividend[63:20] >= 44'(req.divisor)) done_in = 1'b1;
               else state_in = D_RUN;
            end
         end
         default: begin
            rem_in  = ge ? diff[28:0] : trial[28:0];
            quot_in = {quot_ff[46:0], ge};
            sh_in   = sh_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.quot = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gfhs_back.sv =====
// Back end: sequences the multiplies of each term over the shared multiplier,
// keeps the field sums and pole recursion, and forms results.
// Depends on gfhs_pkg, gfhs_mul and gfhs_div.
`default_nettype none

module gfhs_back
   import gfhs_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    queue_empty,
   input  wire term_type                queue_data,
   output logic                         queue_pop,
   input  wire logic [THR_W-1:0]        pole_threshold,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_field_north,
   output logic signed [OUT_W-1:0]      rsp_field_east,
   output logic signed [OUT_W-1:0]      rsp_field_down,
   output logic                         rsp_pole_case
);

   typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH, S_DIV, S_OUT} state_type;
   typedef enum logic [4:0] {
      OP_GCL, OP_HSL, OP_C, OP_GSL, OP_HCL, OP_S, OP_CR, OP_SR, OP_NORTH,
      OP_DOWN1, OP_DOWN2, OP_EAST1, OP_EAST2, OP_PA, OP_PB, OP_PE1, OP_PE2
   } op_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   term_type            item_ff, item_in;
   logic signed [63:0]  t1_ff, t1_in;
   logic signed [63:0]  tmp_ff, tmp_in;
   logic signed [63:0]  c_ff, c_in;
   logic signed [63:0]  s_ff, s_in;
   logic signed [63:0]  cr_ff, cr_in;
   logic signed [63:0]  sr_ff, sr_in;
   logic signed [31:0]  pp_ff, pp_in;
   logic signed [63:0]  sum_n_ff, sum_n_in;
   logic signed [63:0]  sum_e_ff, sum_e_in;
   logic signed [63:0]  sum_d_ff, sum_d_in;
   logic signed [63:0]  sum_p_ff, sum_p_in;
   logic signed [31:0]  prev_ff, prev_in;
   logic signed [31:0]  prev2_ff, prev2_in;
   logic                pole_ff, pole_in;
   logic                out_valid_ff, out_valid_in;
   logic signed [OUT_W-1:0] out_n_ff, out_n_in;
   logic signed [OUT_W-1:0] out_e_ff, out_e_in;
   logic signed [OUT_W-1:0] out_d_ff, out_d_in;
   logic                out_p_ff, out_p_in;

   mul_req_type mreq;
   mul_rsp_type mrsp;
   div_req_type dreq;
   div_rsp_type drsp;

   logic               pole_now;
   logic signed [63:0] pdiff;
   logic signed [31:0] pp_new;
   logic signed [OUT_W-1:0] east_div;
   logic               out_free;

   gfhs_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));
   gfhs_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Operand selection for the shared multiplier.
   always_comb begin
      mreq.start = (state_ff == S_ISSUE);
      mreq.a     = '0;
      mreq.b     = '0;
      unique case (op_ff)
         OP_GCL:   begin mreq.a = 64'($signed(item_ff.coef_g)); mreq.b = 64'($signed(item_ff.cos_m_lon)); end
         OP_HSL:   begin mreq.a = 64'($signed(item_ff.coef_h)); mreq.b = 64'($signed(item_ff.sin_m_lon)); end
         OP_C:     begin mreq.a = tmp_ff; mreq.b = 64'sd1; end
         OP_GSL:   begin mreq.a = 64'($signed(item_ff.coef_g)); mreq.b = 64'($signed(item_ff.sin_m_lon)); end
         OP_HCL:   begin mreq.a = 64'($signed(item_ff.coef_h)); mreq.b = 64'($signed(item_ff.cos_m_lon)); end
         OP_S:     begin mreq.a = tmp_ff; mreq.b = 64'sd1; end
         OP_CR:    begin mreq.a = c_ff; mreq.b = $signed(64'(item_ff.radius_power)); end
         OP_SR:    begin mreq.a = s_ff; mreq.b = $signed(64'(item_ff.radius_power)); end
         OP_NORTH: begin mreq.a = cr_ff; mreq.b = 64'($signed(item_ff.legendre_dp)); end
         OP_DOWN1: begin mreq.a = cr_ff; mreq.b = 64'($signed(item_ff.legendre_p)); end
         OP_DOWN2: begin
            mreq.a = tmp_ff;
            mreq.b = $signed(64'({1'b0, item_ff.degree} + 5'd1) << 28);
         end
         OP_EAST1: begin mreq.a = sr_ff; mreq.b = 64'($signed(item_ff.legendre_p)); end
         OP_EAST2: begin mreq.a = tmp_ff; mreq.b = $signed(64'(item_ff.order) << 28); end
         OP_PA:    begin mreq.a = 64'($signed(item_ff.sin_lat)); mreq.b = 64'(prev_ff); end
         OP_PB:    begin mreq.a = $signed(64'(K_TAB[item_ff.degree])); mreq.b = 64'(prev2_ff); end
         OP_PE1:   begin mreq.a = sr_ff; mreq.b = 64'(pp_ff); end
         default:  begin mreq.a = tmp_ff; mreq.b = $signed(64'(NORM_TAB[item_ff.degree])); end
      endcase
   end

   always_comb begin
      pole_now      = (item_ff.cos_lat <= pole_threshold);
      dreq.start    = (state_ff == S_FINISH) && item_ff.last && !pole_now;
      dreq.dividend = sum_e_ff[63] ? 64'(-sum_e_ff) : 64'(sum_e_ff);
      dreq.divisor  = item_ff.cos_lat;

      // Order-one recursion value, clamped to 32 bits.
      pdiff = ssub64(tmp_ff, mrsp.q);
      if (pdiff > 64'sh0000_0000_7fff_ffff)       pp_new = 32'sh7fff_ffff;
      else if (pdiff < -64'sh0000_0000_8000_0000) pp_new = 32'sh8000_0000;
      else                                         pp_new = pdiff[31:0];

      // Quotient to 48-bit signed with saturation on either side.
      if (!sum_e_ff[63]) begin
         east_div = (drsp.ovf || drsp.quot[47]) ? {1'b0, {(OUT_W-1){1'b1}}} : drsp.quot;
      end else if (drsp.ovf || (drsp.quot[47] && |drsp.quot[46:0])) begin
         east_div = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         east_div = -$signed(drsp.quot);
      end

      out_free = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      t1_in        = t1_ff;
      tmp_in       = tmp_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      cr_in        = cr_ff;
      sr_in        = sr_ff;
      pp_in        = pp_ff;
      sum_n_in     = sum_n_ff;
      sum_e_in     = sum_e_ff;
      sum_d_in     = sum_d_ff;
      sum_p_in     = sum_p_ff;
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      pole_in      = pole_ff;
      out_n_in     = out_n_ff;
      out_e_in     = out_e_ff;
      out_d_in     = out_d_ff;
      out_p_in     = out_p_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      queue_pop    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               item_in   = queue_data;
               op_in     = OP_GCL;
               state_in  = queue_data.term_ok ? S_ISSUE : S_FINISH;
            end
         end
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (mrsp.done) begin
               state_in = S_ISSUE;
               unique case (op_ff)
                  OP_GCL:   begin t1_in = mrsp.raw; op_in = OP_HSL; end
                  OP_HSL:   begin tmp_in = t1_ff + mrsp.raw; op_in = OP_C; end
                  OP_C:     begin c_in = mrsp.q; op_in = OP_GSL; end
                  OP_GSL:   begin t1_in = mrsp.raw; op_in = OP_HCL; end
                  OP_HCL:   begin tmp_in = t1_ff - mrsp.raw; op_in = OP_S; end
                  OP_S:     begin s_in = mrsp.q; op_in = OP_CR; end
                  OP_CR:    begin cr_in = mrsp.q; op_in = OP_SR; end
                  OP_SR:    begin sr_in = mrsp.q; op_in = OP_NORTH; end
                  OP_NORTH: begin sum_n_in = ssub64(sum_n_ff, mrsp.q); op_in = OP_DOWN1; end
                  OP_DOWN1: begin tmp_in = mrsp.q; op_in = OP_DOWN2; end
                  OP_DOWN2: begin sum_d_in = ssub64(sum_d_ff, mrsp.q); op_in = OP_EAST1; end
                  OP_EAST1: begin tmp_in = mrsp.q; op_in = OP_EAST2; end
                  OP_EAST2: begin
                     sum_e_in = sadd64(sum_e_ff, mrsp.q);
                     if (!item_ff.order_one) begin
                        state_in = S_FINISH;
                     end else if (item_ff.degree_one) begin
                        // The degree-one term seeds the recursion with 1.0.
                        pp_in    = ONE_Q28[31:0];
                        prev2_in = prev_ff;
                        prev_in  = ONE_Q28[31:0];
                        op_in    = OP_PE1;
                     end else begin
                        op_in = OP_PA;
                     end
                  end
                  OP_PA:    begin tmp_in = mrsp.q; op_in = OP_PB; end
                  OP_PB: begin
                     pp_in    = pp_new;
                     prev2_in = prev_ff;
                     prev_in  = pp_new;
                     op_in    = OP_PE1;
                  end
                  OP_PE1:   begin tmp_in = mrsp.q; op_in = OP_PE2; end
                  default: begin
                     sum_p_in = sadd64(sum_p_ff, mrsp.q);
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (!item_ff.last) begin
               state_in = S_IDLE;
            end else begin
               pole_in  = pole_now;
               state_in = pole_now ? S_OUT : S_DIV;
            end
         end
         S_DIV: begin
            if (drsp.done) state_in = S_OUT;
         end
         default: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_n_in     = sat48(sum_n_ff);
               out_d_in     = sat48(sum_d_ff);
               out_e_in     = pole_ff ? sat48(sum_p_ff) : east_div;
               out_p_in     = pole_ff;
               sum_n_in     = '0;
               sum_e_in     = '0;
               sum_d_in     = '0;
               sum_p_in     = '0;
               prev_in      = ONE_Q28[31:0];
               prev2_in     = '0;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_GCL;
         sum_n_ff     <= '0;
         sum_e_ff     <= '0;
         sum_d_ff     <= '0;
         sum_p_ff     <= '0;
         prev_ff      <= ONE_Q28[31:0];
         prev2_ff     <= '0;
         pole_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         sum_n_ff     <= sum_n_in;
         sum_e_ff     <= sum_e_in;
         sum_d_ff     <= sum_d_in;
         sum_p_ff     <= sum_p_in;
         prev_ff      <= prev_in;
         prev2_ff     <= prev2_in;
         pole_ff      <= pole_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff  <= item_in;
      t1_ff    <= t1_in;
      tmp_ff   <= tmp_in;
      c_ff     <= c_in;
      s_ff     <= s_in;
      cr_ff    <= cr_in;
      sr_ff    <= sr_in;
      pp_ff    <= pp_in;
      out_n_ff <= out_n_in;
      out_e_ff <= out_e_in;
      out_d_ff <= out_d_in;
      out_p_ff <= out_p_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_field_north = out_n_ff;
   assign rsp_field_east  = out_e_ff;
   assign rsp_field_down  = out_d_ff;
   assign rsp_pole_case   = out_p_ff;

endmodule

`default_nettype wire

// ===== rtl/core/geomagnetic_field_harmonic_sum.sv =====
// A valid term runs 13 multiplies, one after another, on the shared multiplier,
// plus 4 more on order-one terms (2 on degree one); an invalid term runs none.
// The last term adds the serial divide, except in the pole case.
// Throughput is set by the shared multiplier; the queue lets 2 terms wait ahead of it.
// Reset (synchronous, active high) clears sums, recursion, queue and threshold.
`default_nettype none

module geomagnetic_field_harmonic_sum
   import gfhs_pkg::*;
#(
   parameter int MAX_DEGREE = 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Term input channel.
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [3:0]              req_degree,
   input  wire logic [3:0]              req_order,
   input  wire logic [30:0]             req_radius_power,
   input  wire logic signed [31:0]      req_coef_g,
   input  wire logic signed [31:0]      req_coef_h,
   input  wire logic signed [29:0]      req_cos_m_lon,
   input  wire logic signed [29:0]      req_sin_m_lon,
   input  wire logic signed [31:0]      req_legendre_p,
   input  wire logic signed [31:0]      req_legendre_dp,
   input  wire logic [28:0]             req_cos_lat,
   input  wire logic signed [29:0]      req_sin_lat,
   input  wire logic                    req_last,
   // Field result channel.
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_field_north,
   output logic signed [OUT_W-1:0]      rsp_field_east,
   output logic signed [OUT_W-1:0]      rsp_field_down,
   output logic                         rsp_pole_case,
   // Register port.
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   // The only register, the pole threshold, sits at byte address zero.
   // Bit 2 of the address selects the register word; a write to any
   // other word is dropped and reads there return zero.
   logic [THR_W-1:0] thr_ff, thr_in;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && !paddr[2];
   assign thr_in    = csr_write ? pwdata[THR_W-1:0] : thr_ff;
   assign prdata    = paddr[2] ? 32'd0 : 32'(thr_ff);

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= '0;
      else       thr_ff <= thr_in;
   end

   // The front end checks each term and drops it into the queue; a full
   // queue stalls the input transfer.
   logic     q_push, q_pop, q_full, q_empty;
   term_type q_in_data, q_out_data;

   gfhs_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_degree       (req_degree),
      .req_order        (req_order),
      .req_radius_power (req_radius_power),
      .req_coef_g       (req_coef_g),
      .req_coef_h       (req_coef_h),
      .req_cos_m_lon    (req_cos_m_lon),
      .req_sin_m_lon    (req_sin_m_lon),
      .req_legendre_p   (req_legendre_p),
      .req_legendre_dp  (req_legendre_dp),
      .req_cos_lat      (req_cos_lat),
      .req_sin_lat      (req_sin_lat),
      .req_last         (req_last),
      .queue_full       (q_full),
      .push             (q_push),
      .entry            (q_in_data)
   );

   gfhs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end pulls one term at a time, runs its multiplies, and on the
   // last term forms the result in an output register. That register holds a
   // result while the back end goes on with the next evaluation's terms.
   gfhs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (q_empty),
      .queue_data      (q_out_data),
      .queue_pop       (q_pop),
      .pole_threshold  (thr_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_north (rsp_field_north),
      .rsp_field_east  (rsp_field_east),
      .rsp_field_down  (rsp_field_down),
      .rsp_pole_case   (rsp_pole_case)
   );

endmodule

`default_nettype wire

// ===== rtl/core/gfhs_checker.sv =====
// Port-level checks of the harmonic sum block and the bind that attaches them.
// Depends on gfhs_pkg and geomagnetic_field_harmonic_sum_macros.svh.
`default_nettype none
`include "geomagnetic_field_harmonic_sum_macros.svh"

module gfhs_checker
   import gfhs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [OUT_W-1:0]      rsp_field_east,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [31:0]           pwdata,
   input wire logic [31:0]           prdata
);

   logic thr_write;

   assign thr_write = psel && penable && pwrite && !paddr[2];

   // A stalled input transfer stays offered.
   `GFHS_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid)
   // A stalled result stays offered and its east field keeps its value.
   `GFHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `GFHS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_field_east))
   // No result is offered on the first cycle after reset.
   `GFHS_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)
   // A threshold write reads back on the next cycle.
   `GFHS_ASSERT_NEXT(a_thr_readback, clock, reset, thr_write, paddr[2] || prdata == {3'd0, $past(pwdata[28:0])})

endmodule

bind geomagnetic_field_harmonic_sum gfhs_checker u_gfhs_checker (.*);

`default_nettype wire
